// File: hw/rtl/jpsp_pkg.sv
package jpsp_pkg;

   // configuration register
   localparam int IRQ_DELAY_W = 4;
   localparam logic [IRQ_DELAY_W-1:0] IRQ_DELAY_RESET = 4'd3;

   // input and result channel widths
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;

   // item kinds carried on req_tuser
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_BUTTON = 2'd3;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
   } jpsp_result_type;

endpackage

// File: hw/rtl/joypad_serial_port_with_digital_pad.sv
// channel   direction  handshake             payload
// req       in         req_tvalid/req_tready  tdata: address, write_data, buttons; tuser: kind
// rsp       out        rsp_tvalid/rsp_tready  tdata: read_data, irq_line
// csr       in         apb psel/penable       irq_delay_ticks at byte offset 0
//
// one item per cycle while rsp is not stalled: the port state updates at the accepting
// edge and the result lands in the output register on that same edge
// req_tready stays high while the output register is empty or being drained,
// so a stall on rsp holds at most one result and backs up req directly
// reset is synchronous; all port state clears, irq delay returns to 3 ticks
module joypad_serial_port_with_digital_pad
   import jpsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [3:0] address, [11:4] write_data, [27:12] buttons
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] kind
   // result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [7:0] read_data, [8] irq_line
   // configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [IRQ_DELAY_W-1:0] irq_delay;
   logic                   req_accept;
   jpsp_result_type        result;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   jpsp_result_type        rsp_data_ff, rsp_data_in;

   jpsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .irq_delay   (irq_delay)
   );

   // take a new item whenever the output slot is free or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   jpsp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_accept),
      .kind       (req_tuser[1:0]),
      .address    (req_tdata[3:0]),
      .write_data (req_tdata[11:4]),
      .buttons    (req_tdata[27:12]),
      .irq_delay  (irq_delay),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff.irq_line, rsp_data_ff.read_data};

endmodule

// File: hw/rtl/jpsp_csr.sv
module jpsp_csr
   import jpsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output logic [IRQ_DELAY_W-1:0] irq_delay
);

   localparam logic REG_IRQ_DELAY = 1'b0;

   logic [IRQ_DELAY_W-1:0] irq_delay_ff;
   logic [IRQ_DELAY_W-1:0] irq_delay_in;
   logic                   wr_en;

   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      irq_delay_in = irq_delay_ff;
      if (wr_en && csr_paddr[2] == REG_IRQ_DELAY) begin
         irq_delay_in = csr_pwdata[IRQ_DELAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_delay_ff <= IRQ_DELAY_RESET;
      end else begin
         irq_delay_ff <= irq_delay_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_IRQ_DELAY) begin
         csr_prdata = {{(32-IRQ_DELAY_W){1'b0}}, irq_delay_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign irq_delay  = irq_delay_ff;

endmodule

// File: hw/rtl/jpsp_core.sv
module jpsp_core
   import jpsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  logic [1:0]             kind,
   input  logic [3:0]             address,
   input  logic [7:0]             write_data,
   input  logic [15:0]            buttons,
   input  logic [IRQ_DELAY_W-1:0] irq_delay,
   output jpsp_result_type        result
);

   // register offsets
   localparam logic [3:0] ADDR_DATA    = 4'd0;
   localparam logic [3:0] ADDR_STAT    = 4'd4;
   localparam logic [3:0] ADDR_IRQ     = 4'd5;
   localparam logic [3:0] ADDR_MODE_LO = 4'd8;
   localparam logic [3:0] ADDR_MODE_HI = 4'd9;
   localparam logic [3:0] ADDR_CTRL_LO = 4'd10;
   localparam logic [3:0] ADDR_CTRL_HI = 4'd11;
   localparam logic [3:0] ADDR_BAUD_LO = 4'd14;
   localparam logic [3:0] ADDR_BAUD_HI = 4'd15;

   localparam int CTRL_PORT2_BIT  = 13;
   localparam int CTRL_IRQ_ACK_BIT = 4;

   localparam logic [7:0] CMD_START = 8'h01;
   localparam logic [7:0] CMD_READ  = 8'h42;
   localparam logic [7:0] PAD_ID_LO = 8'h41;
   localparam logic [7:0] PAD_ID_HI = 8'h5a;
   localparam logic [7:0] BYTE_IDLE = 8'hff;

   // pad reply phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_ID   = 3'd2;
   localparam logic [2:0] PH_LO   = 3'd3;
   localparam logic [2:0] PH_HI   = 3'd4;

   logic [2:0]             phase_ff, phase_in;
   logic [7:0]             rx_byte_ff, rx_byte_in;
   logic                   rx_pend_ff, rx_pend_in;
   logic                   ack_ff, ack_in;
   logic                   irq_ff, irq_in;
   logic [IRQ_DELAY_W-1:0] count_ff, count_in;
   logic [15:0]            mode_ff, mode_in;
   logic [15:0]            ctrl_ff, ctrl_in;
   logic [15:0]            baud_ff, baud_in;
   logic [15:0]            button_ff, button_in;

   logic [2:0] pad_phase_nxt;
   logic [7:0] pad_byte;
   logic [7:0] rd;

   // pad reply for the byte being written
   always_comb begin
      pad_phase_nxt = PH_IDLE;
      pad_byte      = BYTE_IDLE;
      unique case (phase_ff)
         PH_IDLE: begin
            pad_phase_nxt = (write_data == CMD_START) ? PH_CMD : PH_IDLE;
         end
         PH_CMD: begin
            if (write_data == CMD_READ) begin
               pad_phase_nxt = PH_ID;
               pad_byte      = PAD_ID_LO;
            end
         end
         PH_ID: begin
            pad_phase_nxt = PH_LO;
            pad_byte      = PAD_ID_HI;
         end
         PH_LO: begin
            pad_phase_nxt = PH_HI;
            pad_byte      = ~button_ff[7:0];
         end
         PH_HI: begin
            pad_byte = ~button_ff[15:8];
         end
         default: begin
            pad_phase_nxt = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      rx_byte_in = rx_byte_ff;
      rx_pend_in = rx_pend_ff;
      ack_in     = ack_ff;
      irq_in     = irq_ff;
      count_in   = count_ff;
      mode_in    = mode_ff;
      ctrl_in    = ctrl_ff;
      baud_in    = baud_ff;
      button_in  = button_ff;
      rd         = BYTE_IDLE;
      case (kind)
         KIND_READ: begin
            case (address)
               ADDR_DATA: begin
                  rd         = rx_byte_ff;
                  rx_pend_in = 1'b0;
               end
               ADDR_STAT: begin
                  rd     = {ack_ff, 5'b0, rx_pend_ff, 1'b1};
                  ack_in = 1'b0;
               end
               ADDR_IRQ:     rd = {6'b0, irq_ff, 1'b0};
               ADDR_MODE_LO: rd = mode_ff[7:0];
               ADDR_MODE_HI: rd = mode_ff[15:8];
               ADDR_CTRL_LO: rd = ctrl_ff[7:0];
               ADDR_CTRL_HI: rd = ctrl_ff[15:8];
               ADDR_BAUD_LO: rd = baud_ff[7:0];
               ADDR_BAUD_HI: rd = baud_ff[15:8];
               default:      rd = BYTE_IDLE;
            endcase
         end
         KIND_WRITE: begin
            case (address)
               ADDR_DATA: begin
                  rx_pend_in = 1'b1;
                  if (!ctrl_ff[CTRL_PORT2_BIT]) begin
                     phase_in   = pad_phase_nxt;
                     rx_byte_in = pad_byte;
                     ack_in     = (pad_phase_nxt != PH_IDLE);
                     if (pad_phase_nxt != PH_IDLE) begin
                        count_in = irq_delay;
                     end
                  end
               end
               ADDR_MODE_LO: mode_in[7:0]  = write_data;
               ADDR_MODE_HI: mode_in[15:8] = write_data;
               ADDR_CTRL_LO: begin
                  ctrl_in[7:0] = write_data;
                  if (write_data[CTRL_IRQ_ACK_BIT]) begin
                     irq_in = 1'b0;
                  end
               end
               ADDR_CTRL_HI: ctrl_in[15:8] = write_data;
               ADDR_BAUD_LO: baud_in[7:0]  = write_data;
               ADDR_BAUD_HI: baud_in[15:8] = write_data;
               default: ;
            endcase
         end
         KIND_TICK: begin
            if (count_ff != '0) begin
               count_in = count_ff - {{(IRQ_DELAY_W-1){1'b0}}, 1'b1};
               if (count_ff == {{(IRQ_DELAY_W-1){1'b0}}, 1'b1}) begin
                  irq_in = 1'b1;
               end
            end
         end
         default: begin
            button_in = buttons;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         rx_byte_ff <= '0;
         rx_pend_ff <= 1'b0;
         ack_ff     <= 1'b0;
         irq_ff     <= 1'b0;
         count_ff   <= '0;
         mode_ff    <= '0;
         ctrl_ff    <= '0;
         baud_ff    <= '0;
         button_ff  <= '0;
      end else if (item_valid) begin
         phase_ff   <= phase_in;
         rx_byte_ff <= rx_byte_in;
         rx_pend_ff <= rx_pend_in;
         ack_ff     <= ack_in;
         irq_ff     <= irq_in;
         count_ff   <= count_in;
         mode_ff    <= mode_in;
         ctrl_ff    <= ctrl_in;
         baud_ff    <= baud_in;
         button_ff  <= button_in;
      end
   end

   assign result.read_data = rd;
   assign result.irq_line  = irq_in;

endmodule

// File: tb/tb_joypad_serial_port_with_digital_pad.sv
`timescale 1ns / 100ps

module tb_joypad_serial_port_with_digital_pad;
   import jpsp_pkg::*;

   // bus byte offsets of the port register map
   localparam logic [3:0] ADDR_DATA    = 4'd0;
   localparam logic [3:0] ADDR_STAT    = 4'd4;
   localparam logic [3:0] ADDR_IRQ     = 4'd5;
   localparam logic [3:0] ADDR_MODE_LO = 4'd8;
   localparam logic [3:0] ADDR_MODE_HI = 4'd9;
   localparam logic [3:0] ADDR_CTRL_LO = 4'd10;
   localparam logic [3:0] ADDR_CTRL_HI = 4'd11;
   localparam logic [3:0] ADDR_BAUD_LO = 4'd14;
   localparam logic [3:0] ADDR_BAUD_HI = 4'd15;
   localparam logic [3:0] ADDR_UNUSED  = 4'd3;

   // control bits
   localparam int CTRL_IRQ_ACK_BIT = 4;
   localparam int CTRL_PORT2_BIT   = 13;
   localparam logic [7:0] CTRL_IRQ_ACK = 8'h10;
   localparam logic [7:0] CTRL_PORT2   = 8'h20;

   // pad protocol bytes
   localparam logic [7:0] CMD_SELECT = 8'h01;
   localparam logic [7:0] CMD_POLL   = 8'h42;
   localparam logic [7:0] PAD_ID     = 8'h41;
   localparam logic [7:0] PAD_READY  = 8'h5a;
   localparam logic [7:0] IDLE_BYTE  = 8'hff;

   // pad reply stages
   localparam logic [2:0] STAGE_IDLE     = 3'd0;
   localparam logic [2:0] STAGE_SELECTED = 3'd1;
   localparam logic [2:0] STAGE_ID       = 3'd2;
   localparam logic [2:0] STAGE_LOW      = 3'd3;
   localparam logic [2:0] STAGE_HIGH     = 3'd4;

   // csr byte addresses
   localparam logic [2:0] CSR_IRQ_DELAY = 3'd0;
   localparam logic [2:0] CSR_SPARE     = 3'd4;

   localparam int DRAIN_CYCLES    = 4;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 475;
   localparam int RUN_LIMIT_NS    = 3_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // [3:0] address, [11:4] write_data, [27:12] buttons
   logic [REQ_TUSER_W-1:0] req_tuser = '0;  // [1:0] kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // [7:0] read_data, [8] irq_line
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [2:0]             csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   joypad_serial_port_with_digital_pad u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted port state, mirrors what the block should hold
   logic [3:0]  irq_delay   = IRQ_DELAY_RESET;
   logic [2:0]  pad_stage   = STAGE_IDLE;
   logic [7:0]  rx_data     = 8'd0;
   logic        rx_full     = 1'b0;
   logic        ack_bit     = 1'b0;
   logic        irq_bit     = 1'b0;
   logic [3:0]  irq_count   = 4'd0;
   logic [15:0] mode_word   = 16'd0;
   logic [15:0] ctrl_word   = 16'd0;
   logic [15:0] baud_word   = 16'd0;
   logic [15:0] pad_buttons = 16'd0;

   // results still owed by the block, oldest first
   jpsp_result_type port_results_due[$];

   int unsigned items_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned irq_fired       = 0;
   int unsigned error_count     = 0;

   // flow control knobs in percent: of items that get an idle gap, of cycles that stall
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;

   // long hold-off on the result side, asked by the test, counted here
   int unsigned hold_asked = 0;
   int unsigned hold_seen  = 0;
   int unsigned hold_left  = 0;

   // the pad answers one byte per transfer and moves to its next stage
   function automatic logic [7:0] pad_answer(input logic [7:0] cmd);
      logic [7:0] ans;
      ans = IDLE_BYTE;
      case (pad_stage)
         STAGE_IDLE: begin
            if (cmd == CMD_SELECT) pad_stage = STAGE_SELECTED;
         end
         STAGE_SELECTED: begin
            if (cmd == CMD_POLL) begin
               pad_stage = STAGE_ID;
               ans = PAD_ID;
            end else begin
               pad_stage = STAGE_IDLE;
            end
         end
         STAGE_ID: begin
            pad_stage = STAGE_LOW;
            ans = PAD_READY;
         end
         STAGE_LOW: begin
            pad_stage = STAGE_HIGH;
            ans = ~pad_buttons[7:0];
         end
         STAGE_HIGH: begin
            pad_stage = STAGE_IDLE;
            ans = ~pad_buttons[15:8];
         end
         default: pad_stage = STAGE_IDLE;
      endcase
      return ans;
   endfunction

   // applies one item to the predicted state and returns the result it owes
   function automatic jpsp_result_type port_respond(input logic [1:0] kind,
         input logic [3:0] addr, input logic [7:0] wdata, input logic [15:0] btn);
      jpsp_result_type res;
      res.read_data = IDLE_BYTE;
      case (kind)
         KIND_READ: begin
            case (addr)
               ADDR_DATA: begin
                  rx_full = 1'b0;
                  res.read_data = rx_data;
               end
               ADDR_STAT: begin
                  res.read_data = {ack_bit, 5'd0, rx_full, 1'b1};
                  ack_bit = 1'b0;
               end
               ADDR_IRQ:     res.read_data = {6'd0, irq_bit, 1'b0};
               ADDR_MODE_LO: res.read_data = mode_word[7:0];
               ADDR_MODE_HI: res.read_data = mode_word[15:8];
               ADDR_CTRL_LO: res.read_data = ctrl_word[7:0];
               ADDR_CTRL_HI: res.read_data = ctrl_word[15:8];
               ADDR_BAUD_LO: res.read_data = baud_word[7:0];
               ADDR_BAUD_HI: res.read_data = baud_word[15:8];
               default: ;
            endcase
         end
         KIND_WRITE: begin
            case (addr)
               ADDR_DATA: begin
                  // with port 2 selected only the pending flag moves
                  rx_full = 1'b1;
                  if (!ctrl_word[CTRL_PORT2_BIT]) begin
                     rx_data = pad_answer(wdata);
                     ack_bit = (pad_stage != STAGE_IDLE);
                     if (ack_bit) irq_count = irq_delay;
                  end
               end
               ADDR_MODE_LO: mode_word[7:0] = wdata;
               ADDR_MODE_HI: mode_word[15:8] = wdata;
               ADDR_CTRL_LO: begin
                  ctrl_word[7:0] = wdata;
                  if (wdata[CTRL_IRQ_ACK_BIT]) irq_bit = 1'b0;
               end
               ADDR_CTRL_HI: ctrl_word[15:8] = wdata;
               ADDR_BAUD_LO: baud_word[7:0] = wdata;
               ADDR_BAUD_HI: baud_word[15:8] = wdata;
               default: ;
            endcase
         end
         KIND_TICK: begin
            // an idle countdown ignores the tick
            if (irq_count != 4'd0) begin
               irq_count = irq_count - 4'd1;
               if (irq_count == 4'd0) begin
                  irq_bit = 1'b1;
                  irq_fired++;
               end
            end
         end
         default: pad_buttons = btn;
      endcase
      res.irq_line = irq_bit;
      return res;
   endfunction

   // result side: random stalls, plus the long hold-off when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // every accepted result item is checked against the oldest prediction
   jpsp_result_type due_result;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (port_results_due.size() == 0) begin
            $error("result item with nothing outstanding: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            due_result = port_results_due.pop_front();
            results_checked++;
            if (rsp_tdata[7:0] !== due_result.read_data) begin
               $error("read_data mismatch: expected %h, actual %h",
                      due_result.read_data, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[8] !== due_result.irq_line) begin
               $error("irq_line mismatch: expected %b, actual %b",
                      due_result.irq_line, rsp_tdata[8]);
               error_count++;
            end
         end
      end
   end

   // offers one item, predicts its result once the handshake completes
   task automatic send_item(input logic [1:0] kind, input logic [3:0] addr,
                            input logic [7:0] wdata, input logic [15:0] btn);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, btn, wdata, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      port_results_due.push_back(port_respond(kind, addr, wdata, btn));
      items_sent++;
   endtask

   // don't-care fields carry random bits so every input bit toggles
   task automatic bus_read(input logic [3:0] addr);
      send_item(KIND_READ, addr, 8'($urandom_range(255)), 16'($urandom_range(16'hffff)));
   endtask

   task automatic bus_write(input logic [3:0] addr, input logic [7:0] wdata);
      send_item(KIND_WRITE, addr, wdata, 16'($urandom_range(16'hffff)));
   endtask

   task automatic tick();
      send_item(KIND_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)),
                16'($urandom_range(16'hffff)));
   endtask

   task automatic press(input logic [15:0] btn);
      send_item(KIND_BUTTON, 4'($urandom_range(15)), 8'($urandom_range(255)), btn);
   endtask

   // stop offering, let every owed result drain, then hold the bus quiet before returning
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (port_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup then access phase; register takes the value on the access edge
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == CSR_IRQ_DELAY) irq_delay = data[IRQ_DELAY_W-1:0];
   endtask

   // byte registers, a high half and a low half, plus an unmapped offset
   task automatic test_register_access();
      bus_write(ADDR_MODE_HI, 8'hff);
      bus_read(ADDR_MODE_HI);
      bus_write(ADDR_BAUD_LO, 8'ha5);
      bus_read(ADDR_BAUD_LO);
      bus_write(ADDR_UNUSED, 8'h00);
      bus_read(ADDR_UNUSED);
   endtask

   // one full poll with every button pressed, then the two refused-byte cases
   task automatic test_pad_exchange();
      press(16'hffff);
      bus_write(ADDR_DATA, CMD_SELECT);
      bus_read(ADDR_STAT);
      bus_write(ADDR_DATA, CMD_POLL);
      bus_write(ADDR_DATA, 8'h00);
      bus_write(ADDR_DATA, 8'hff);
      bus_read(ADDR_DATA);
      bus_write(ADDR_DATA, 8'h00);
      bus_read(ADDR_DATA);
      bus_write(ADDR_DATA, 8'h07);      // idle pad refuses anything but select
      bus_write(ADDR_DATA, CMD_SELECT);
      bus_write(ADDR_DATA, 8'h33);      // selected pad drops back on a non-poll
      bus_read(ADDR_STAT);
   endtask

   // transfers with port 2 selected only raise rx pending
   task automatic test_port_two();
      bus_write(ADDR_CTRL_HI, CTRL_PORT2);
      bus_write(ADDR_DATA, CMD_SELECT);
      bus_read(ADDR_STAT);
      bus_read(ADDR_CTRL_HI);
      bus_write(ADDR_CTRL_HI, 8'h00);
   endtask

   // zero delay never fires, the spare csr slot is ignored, delay 1 fires
   task automatic test_irq_delay();
      tick();
      wait_idle();
      csr_write(CSR_IRQ_DELAY, 32'd0);
      bus_write(ADDR_DATA, CMD_SELECT);
      tick();
      bus_read(ADDR_IRQ);
      wait_idle();
      csr_write(CSR_SPARE, $urandom);
      bus_write(ADDR_DATA, CMD_POLL);
      tick();
      wait_idle();
      csr_write(CSR_IRQ_DELAY, 32'd1);
      bus_write(ADDR_DATA, 8'h00);
      tick();
      bus_read(ADDR_IRQ);
      bus_write(ADDR_CTRL_LO, CTRL_IRQ_ACK);
      bus_write(ADDR_DATA, 8'h00);
      bus_write(ADDR_DATA, 8'h00);
      wait_idle();
   endtask

   task automatic noise_item();
      send_item(2'($urandom_range(3)), 4'($urandom_range(15)), 8'($urandom_range(255)),
                16'($urandom_range(16'hffff)));
   endtask

   // output held off for a long stretch while the input keeps offering
   task automatic test_backpressure();
      wait_idle();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_asked++;
      repeat (40) noise_item();
      wait_idle();
   endtask

   // status, data and irq reads, ticks and button changes mixed into a poll
   task automatic side_item();
      case ($urandom_range(4))
         0: bus_read(ADDR_DATA);
         1: bus_read(ADDR_STAT);
         2: tick();
         3: bus_read(ADDR_IRQ);
         default: press(16'($urandom_range(16'hffff)));
      endcase
   endtask

   // mostly well-formed poll sequences with random content
   task automatic pad_session();
      logic [7:0] ctrl_hi;
      logic [7:0] cmd;
      int unsigned k;
      // usually steer back to port 1, now and then select port 2
      if (ctrl_word[CTRL_PORT2_BIT] ? ($urandom_range(99) < 85) : ($urandom_range(99) < 10)) begin
         ctrl_hi = 8'($urandom_range(255));
         if (ctrl_word[CTRL_PORT2_BIT]) ctrl_hi[CTRL_PORT2_BIT-8] = 1'b0;
         bus_write(ADDR_CTRL_HI, ctrl_hi);
      end
      if ($urandom_range(99) < 30) press(16'($urandom_range(16'hffff)));
      for (k = 0; k < 5; k++) begin
         cmd = 8'($urandom_range(255));
         if (k == 0 && $urandom_range(99) < 90) cmd = CMD_SELECT;
         if (k == 1 && $urandom_range(99) < 90) cmd = CMD_POLL;
         bus_write(ADDR_DATA, cmd);
         if ($urandom_range(99) < 35) side_item();
      end
      // enough ticks now and then to run out the longest delay
      repeat ($urandom_range(16)) tick();
      bus_read(ADDR_IRQ);
      if ($urandom_range(1)) bus_write(ADDR_CTRL_LO, 8'($urandom_range(255)) | CTRL_IRQ_ACK);
   endtask

   // four flow-control phases, each with its own interrupt delay
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned goal;
      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               csr_write(CSR_IRQ_DELAY, 32'd15);
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               csr_write(CSR_IRQ_DELAY, 32'd1);
               req_idle_pct = 53;
               rsp_stall_pct = 0;
            end
            2: begin
               csr_write(CSR_IRQ_DELAY, $urandom_range(2, 14));
               req_idle_pct = 0;
               rsp_stall_pct = 53;
            end
            default: begin
               csr_write(CSR_IRQ_DELAY, 32'd0);
               req_idle_pct = 21;
               rsp_stall_pct = 21;
            end
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            if ($urandom_range(99) < 70) pad_session();
            else noise_item();
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_pad_exchange();
      test_port_two();
      test_irq_delay();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      $display("covered %0d items and %0d checked results, %0d interrupts fired",
               items_sent, results_checked, irq_fired);
      $display("under free flow, input gaps, output stalls, both, and a long output hold-off");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #(RUN_LIMIT_NS);
      $error("run did not finish: %0d results still outstanding", port_results_due.size());
      $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/jpsp_pkg.sv
hw/rtl/jpsp_csr.sv
hw/rtl/jpsp_core.sv
hw/rtl/joypad_serial_port_with_digital_pad.sv
tb/tb_joypad_serial_port_with_digital_pad.sv
